// File: rtl/fbpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared sizes, codes and types of the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	// Pool geometry (chunk size is a power of two)
	localparam int POOL_BYTES  = 4096;
	localparam int CHUNK_BYTES = 64;
	localparam int CHUNK_COUNT = POOL_BYTES / CHUNK_BYTES;
	localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
	localparam int IDX_W       = $clog2(CHUNK_COUNT);
	localparam int LINK_W      = $clog2(CHUNK_COUNT + 1);
	localparam int CNT_W       = $clog2(CHUNK_COUNT + 1);
	localparam int ADDR_W      = 32;

	// Link value meaning "no successor"
	localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(CHUNK_COUNT);
	// Offset of the last chunk from the pool base
	localparam logic [ADDR_W:0] LAST_OFF = (ADDR_W + 1)'((CHUNK_COUNT - 1) * CHUNK_BYTES);
	localparam logic [ADDR_W-1:0] ALIGN_MASK = ADDR_W'(CHUNK_BYTES - 1);

	// Stream widths
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int S_TDATA_W   = ((FUNC_W + ADDR_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = ((STATUS_W + ADDR_W + 7) / 8) * 8;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ALLOCATED   = 3'd0,
		STAT_FREED       = 3'd1,
		STAT_INITIALIZED = 3'd2,
		STAT_NOT_INIT    = 3'd3,
		STAT_EMPTY       = 3'd4,
		STAT_BAD         = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_FREE,
		ST_INIT,
		ST_RESP
	} state_t;

	// Link memory write port
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [LINK_W-1:0] wdata;
	} ram_wr_t;

	// Finished result handed to the output register
	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [ADDR_W-1:0] addr;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/fixed_block_pool_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool allocator with a FIFO free list kept in a link memory.
//
//   channel  | dir | beat contents
//   ---------+-----+------------------------------------------------
//   s_axis   | in  | func, free_address
//   m_axis   | out | status, chunk_address
//   cfg      | in  | pool_base write, one register
//
// Allocate and free go through accept, then the link read result or the
// second link write. Errors go from accept to the reply. Init sweeps every
// link entry, one a cycle, then replies.
// One request is in flight at a time; a result waiting in the output register
// stalls only the finishing step of the next request.
// Reset clears control state; the link memory is not reset (init and free write it).
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [1:0] func, [33:2] free_address, upper bits zero
	input  wire  [fbpa_pkg::S_TDATA_W-1:0]        s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// [2:0] status, [34:3] chunk_address, upper bits zero
	output logic [fbpa_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	input  wire                                   cfg_we,
	input  wire  [fbpa_pkg::ADDR_W-1:0]           cfg_wdata
);
	import fbpa_pkg::*;

	logic [ADDR_W-1:0] pool_base_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              out_free;
	result_t           res;
	ram_wr_t           ram_wr;
	logic [IDX_W-1:0]  ram_raddr;
	logic [LINK_W-1:0] ram_rdata;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
		end else if (cfg_we) begin
			pool_base_q <= cfg_wdata;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	fbpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pool_base    (pool_base_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.func         (s_axis_tdata[FUNC_W-1:0]),
		.free_address (s_axis_tdata[FUNC_W+ADDR_W-1:FUNC_W]),
		.out_free     (out_free),
		.res          (res),
		.ram_wr       (ram_wr),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	fbpa_link_ram u_link_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_status_q <= res.status;
			out_addr_q   <= res.addr;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(M_TDATA_W - STATUS_W - ADDR_W)'(0), out_addr_q, out_status_q};

	// a new result never lands on one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result written over a pending beat");

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second request taken while one is in flight");

	// address is zero unless a chunk was handed out
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_status_q != STAT_ALLOCATED) |-> (out_addr_q == '0))
		else $error("nonzero address on a non-allocate result");

	// memory writes only while a request is being worked on
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tready && !s_axis_tvalid) |-> !ram_wr.we)
		else $error("link memory written while idle");

endmodule
`default_nettype wire

// File: rtl/fbpa_link_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_link_ram
// Successor-link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbpa_link_ram (
	input  wire                                clk,
	input  fbpa_pkg::ram_wr_t                  wr,
	input  wire  [fbpa_pkg::IDX_W-1:0]         raddr,
	output logic [fbpa_pkg::LINK_W-1:0]        rdata
);
	import fbpa_pkg::*;

	logic [LINK_W-1:0] mem [CHUNK_COUNT];

	// write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/fbpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Free-list sequencer: head/tail/count registers, operation decode, init
// sweep and the read-modify-write steps on the link memory.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  [fbpa_pkg::ADDR_W-1:0]        pool_base,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [fbpa_pkg::FUNC_W-1:0]        func,
	input  wire  [fbpa_pkg::ADDR_W-1:0]        free_address,
	input  wire                                out_free,
	output fbpa_pkg::result_t                  res,
	output fbpa_pkg::ram_wr_t                  ram_wr,
	output logic [fbpa_pkg::IDX_W-1:0]         ram_raddr,
	input  wire  [fbpa_pkg::LINK_W-1:0]        ram_rdata
);
	import fbpa_pkg::*;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  head_q, tail_q, idx_q, sweep_q;
	logic [CNT_W-1:0]  count_q;
	logic              ready_q;
	status_t           resp_q, idle_status;

	logic              acc;
	logic              full;
	logic              sweep_last;
	logic [ADDR_W:0]   last_addr;
	logic              in_range, aligned, free_ok;
	logic [ADDR_W-1:0] offset;
	logic [IDX_W-1:0]  free_idx;

	assign acc        = in_valid && in_ready;
	assign full       = (count_q == CNT_W'(CHUNK_COUNT));
	assign sweep_last = (sweep_q == IDX_W'(CHUNK_COUNT - 1));

	// free address check: range without wrap, alignment, something allocated
	assign last_addr = {1'b0, pool_base} + LAST_OFF;
	assign in_range  = (free_address >= pool_base) && ({1'b0, free_address} <= last_addr);
	assign offset    = free_address - pool_base;
	assign aligned   = ((offset & ALIGN_MASK) == '0);
	assign free_idx  = IDX_W'(offset >> CHUNK_SHIFT);
	assign free_ok   = in_range && aligned && (count_q != '0);

	// head link is always being read; data is valid in the cycle after accept
	assign ram_raddr = head_q;

	// next state
	always_comb begin
		state_d     = state_q;
		idle_status = STAT_BAD;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = ST_RESP;
					case (func)
						FUNC_INIT: begin
							state_d = ST_INIT;
						end
						FUNC_ALLOC: begin
							if (!ready_q) begin
								idle_status = STAT_NOT_INIT;
							end else if (full) begin
								idle_status = STAT_EMPTY;
							end else begin
								state_d = ST_ALLOC;
							end
						end
						FUNC_FREE: begin
							if (!ready_q) begin
								idle_status = STAT_NOT_INIT;
							end else if (free_ok) begin
								state_d = ST_FREE;
							end
						end
						default: begin
							idle_status = STAT_BAD;
						end
					endcase
				end
			end
			ST_ALLOC, ST_FREE, ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_INIT: begin
				if (sweep_last) begin
					state_d = ST_RESP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs: handshake, memory writes, result
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		ram_wr       = '0;
		res          = '0;
		res.status   = resp_q;
		case (state_q)
			ST_IDLE: begin
				// freed chunk becomes the new list end
				if (acc && func == FUNC_FREE && ready_q && free_ok) begin
					ram_wr.we    = 1'b1;
					ram_wr.waddr = free_idx;
					ram_wr.wdata = NO_LINK;
				end
			end
			ST_ALLOC: begin
				res.valid  = out_free;
				res.status = STAT_ALLOCATED;
				res.addr   = pool_base + (ADDR_W'(head_q) << CHUNK_SHIFT);
			end
			ST_FREE: begin
				// old tail points at the freed chunk
				ram_wr.we    = out_free;
				ram_wr.waddr = tail_q;
				ram_wr.wdata = LINK_W'(idx_q);
				res.valid    = out_free;
				res.status   = STAT_FREED;
			end
			ST_INIT: begin
				ram_wr.we    = 1'b1;
				ram_wr.waddr = sweep_q;
				ram_wr.wdata = sweep_last ? NO_LINK : LINK_W'(sweep_q) + LINK_W'(1);
			end
			ST_RESP: begin
				res.valid = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// free-list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ready_q <= 1'b0;
			sweep_q <= '0;
			resp_q  <= STAT_BAD;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					sweep_q <= '0;
					idx_q   <= free_idx;
					resp_q  <= idle_status;
				end
				ST_ALLOC: begin
					if (out_free) begin
						if (ram_rdata != NO_LINK) begin
							head_q <= IDX_W'(ram_rdata);
						end
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_FREE: begin
					if (out_free) begin
						tail_q <= idx_q;
						if (full) begin
							head_q <= idx_q;
						end
						count_q <= count_q - CNT_W'(1);
					end
				end
				ST_INIT: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (sweep_last) begin
						head_q  <= '0;
						tail_q  <= IDX_W'(CHUNK_COUNT - 1);
						count_q <= '0;
						ready_q <= 1'b1;
						resp_q  <= STAT_INITIALIZED;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: test/tb_fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator
// Self-checking bench for the block pool allocator. A short table of requests
// exercises the corner cases: use before init, bad and misaligned frees, a
// free with nothing handed out, the unused opcode and re-init. Random
// alloc/free traffic follows for several pool base settings, with pool
// drains, noise frees, random sender gaps and reply back-pressure. Each reply
// is checked against the table or a cycle-free free-list model in this bench.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;
	import fbpa_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int PHASE_ITEMS    = 175;
	localparam int CHOKE_CYCLES   = 400;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		status_t           st;
		logic [ADDR_W-1:0] chunk;
	} reply_t;

	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [ADDR_W-1:0] addr;
		logic              typed;
		status_t           want_st;
		logic [ADDR_W-1:0] want_chunk;
	} probe_row_t;

	// DUT signals
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	wire                  s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	wire                  m_tvalid;
	logic                 m_tready = 1'b0;
	wire  [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we = 1'b0;
	logic [ADDR_W-1:0]    cfg_wdata = '0;

	// Free-list model state
	logic [ADDR_W-1:0] base_m = '0;
	logic [LINK_W-1:0] link_m [CHUNK_COUNT];
	logic [IDX_W-1:0]  head_m = '0;
	logic [IDX_W-1:0]  tail_m = '0;
	logic [CNT_W-1:0]  count_m = '0;
	bit                ready_m = 1'b0;

	reply_t            replies_due [$];
	logic [ADDR_W-1:0] held_chunks [$];
	int                mismatches = 0;
	bit                choke_replies = 1'b0;
	bit                steady_feed = 1'b0;

	// Opening probes, pool base at its reset value of zero
	probe_row_t opening_probes [0:16] = '{
		'{FUNC_ALLOC,  32'h0000_0000, 1'b1, STAT_NOT_INIT,    32'h0000_0000},
		'{FUNC_FREE,   32'h0000_0000, 1'b1, STAT_NOT_INIT,    32'h0000_0000},
		'{FUNC_FREE,   32'hFFFF_FFFF, 1'b1, STAT_NOT_INIT,    32'h0000_0000},
		'{FUNC_UNUSED, 32'h0000_0000, 1'b1, STAT_BAD,         32'h0000_0000},
		'{FUNC_INIT,   32'h0000_0000, 1'b1, STAT_INITIALIZED, 32'h0000_0000},
		'{FUNC_FREE,   32'h0000_0000, 1'b1, STAT_BAD,         32'h0000_0000},
		'{FUNC_ALLOC,  32'hFFFF_FFFF, 1'b1, STAT_ALLOCATED,   32'h0000_0000},
		'{FUNC_ALLOC,  32'h0000_0000, 1'b1, STAT_ALLOCATED,   32'h0000_0040},
		'{FUNC_FREE,   32'h0000_0020, 1'b1, STAT_BAD,         32'h0000_0000},
		'{FUNC_FREE,   32'h0000_1000, 1'b1, STAT_BAD,         32'h0000_0000},
		'{FUNC_FREE,   32'hFFFF_FFFF, 1'b1, STAT_BAD,         32'h0000_0000},
		'{FUNC_FREE,   32'h0000_0040, 1'b0, STAT_FREED,       32'h0000_0000},
		'{FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, STAT_BAD,         32'h0000_0000},
		'{FUNC_ALLOC,  32'h0000_0000, 1'b0, STAT_ALLOCATED,   32'h0000_0000},
		'{FUNC_FREE,   32'h0000_0000, 1'b0, STAT_FREED,       32'h0000_0000},
		'{FUNC_INIT,   32'hFFFF_FFFF, 1'b1, STAT_INITIALIZED, 32'h0000_0000},
		'{FUNC_ALLOC,  32'h0000_0000, 1'b0, STAT_ALLOCATED,   32'h0000_0000}
	};

	fixed_block_pool_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// Free-list model: apply one request, return the reply it earns
	function automatic void pool_answer(input logic [FUNC_W-1:0] op,
			input logic [ADDR_W-1:0] addr, output reply_t rep);
		logic [ADDR_W:0]   top_addr;
		logic [ADDR_W-1:0] off;
		logic [IDX_W-1:0]  idx;
		int                i;
		rep.st = STAT_BAD;
		rep.chunk = '0;
		case (op)
			FUNC_INIT: begin
				for (i = 0; i < CHUNK_COUNT; i++)
					link_m[i] = (i + 1 < CHUNK_COUNT) ? LINK_W'(i + 1) : NO_LINK;
				head_m = '0;
				tail_m = IDX_W'(CHUNK_COUNT - 1);
				count_m = '0;
				ready_m = 1'b1;
				rep.st = STAT_INITIALIZED;
			end
			FUNC_ALLOC: begin
				if (!ready_m)
					rep.st = STAT_NOT_INIT;
				else if (count_m >= CHUNK_COUNT)
					rep.st = STAT_EMPTY;
				else begin
					rep.chunk = base_m + ADDR_W'(head_m) * ADDR_W'(CHUNK_BYTES);
					if (link_m[head_m] != NO_LINK)
						head_m = IDX_W'(link_m[head_m]);
					count_m = count_m + 1'b1;
					rep.st = STAT_ALLOCATED;
				end
			end
			FUNC_FREE: begin
				top_addr = {1'b0, base_m} + LAST_OFF;
				off = addr - base_m;
				if (!ready_m)
					rep.st = STAT_NOT_INIT;
				else if ({1'b0, addr} < {1'b0, base_m} || {1'b0, addr} > top_addr)
					rep.st = STAT_BAD;
				else if (off % CHUNK_BYTES != 0)
					rep.st = STAT_BAD;
				else if (count_m == 0)
					rep.st = STAT_BAD;
				else begin
					idx = IDX_W'(off / CHUNK_BYTES);
					link_m[idx] = NO_LINK;
					link_m[tail_m] = LINK_W'(idx);
					tail_m = idx;
					if (count_m == CHUNK_COUNT)
						head_m = idx;
					count_m = count_m - 1'b1;
					rep.st = STAT_FREED;
				end
			end
			default: rep.st = STAT_BAD;
		endcase
	endfunction

	// Sender gap: mostly none or short, a few long, with calm stretches
	function automatic int feed_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_feed)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one request beat, update the model once it is taken
	task automatic send_req(input logic [FUNC_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic typed, input reply_t typed_rep, output status_t st_out);
		int     gap;
		reply_t rep;
		gap = feed_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({addr, op});
		do @(posedge clk); while (!s_tready);
		pool_answer(op, addr, rep);
		replies_due.push_back(typed ? typed_rep : rep);
		st_out = rep.st;
		if (op == FUNC_INIT)
			held_chunks.delete();
		if (rep.st == STAT_ALLOCATED)
			held_chunks.push_back(rep.chunk);
	endtask

	task automatic send_op(input logic [FUNC_W-1:0] op, input logic [ADDR_W-1:0] addr,
			output status_t st_out);
		send_req(op, addr, 1'b0, '0, st_out);
	endtask

	// Wait for every reply, then write the pool base while idle
	task automatic set_pool_base(input logic [ADDR_W-1:0] value);
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_m = value;
	endtask

	// Hand out chunks until the pool runs dry, then cycle one back
	task automatic drain_pool(inout int sent);
		status_t st;
		int      guard;
		int      pick;
		guard = 0;
		do begin
			send_op(FUNC_ALLOC, $urandom, st);
			guard++;
		end while (st == STAT_ALLOCATED && guard < CHUNK_COUNT + 2);
		sent += guard;
		if (held_chunks.size() > 0) begin
			pick = $urandom_range(0, held_chunks.size() - 1);
			send_op(FUNC_FREE, held_chunks[pick], st);
			held_chunks.delete(pick);
			sent++;
		end
		send_op(FUNC_ALLOC, '0, st);
		send_op(FUNC_ALLOC, '0, st);
		sent += 2;
	endtask

	// One random request, weighted toward well-formed alloc/free traffic
	task automatic random_req(inout int sent);
		int                r;
		int                pick;
		logic [ADDR_W-1:0] addr;
		status_t           st;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 39) == 0)
			steady_feed = ~steady_feed;
		if (r < 2)
			send_op(FUNC_INIT, $urandom, st);
		else if (r < 5)
			send_op(FUNC_UNUSED, $urandom, st);
		else if (r < 9)
			send_op(FUNC_FREE, $urandom, st);
		else if (r < 15) begin
			// near the pool edges, aligned or not
			addr = base_m + ADDR_W'($urandom_range(0, CHUNK_COUNT + 1) * CHUNK_BYTES)
				- ADDR_W'(CHUNK_BYTES);
			if ($urandom_range(0, 1))
				addr = addr + ADDR_W'($urandom_range(1, CHUNK_BYTES - 1));
			send_op(FUNC_FREE, addr, st);
		end else if (r < 17) begin
			drain_pool(sent);
			return;
		end else if (r < 58 || held_chunks.size() == 0)
			send_op(FUNC_ALLOC, $urandom, st);
		else begin
			pick = $urandom_range(0, held_chunks.size() - 1);
			send_op(FUNC_FREE, held_chunks[pick], st);
			held_chunks.delete(pick);
		end
		sent++;
	endtask

	// Receiver ready: random runs and stalls, plus long hold-offs on request
	initial begin
		int run;
		int stall;
		int r;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (choke_replies) begin
				m_tready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
				choke_replies = 1'b0;
			end
			r = $urandom_range(0, 99);
			run = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 30);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			r = $urandom_range(0, 99);
			stall = (r < 50) ? $urandom_range(1, 3) :
				(r < 90) ? $urandom_range(4, 10) : $urandom_range(15, 50);
			m_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	// Reply checker
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected reply beat, status %0d chunk %h",
					$time, m_tdata[STATUS_W-1:0], m_tdata[STATUS_W +: ADDR_W]);
			end else begin
				want = replies_due.pop_front();
				if (m_tdata[STATUS_W-1:0] !== want.st
						|| m_tdata[STATUS_W +: ADDR_W] !== want.chunk) begin
					mismatches++;
					$display("%0t: reply mismatch: expected status %0d chunk %h,",
						$time, want.st, want.chunk,
						" got status %0d chunk %h",
						m_tdata[STATUS_W-1:0], m_tdata[STATUS_W +: ADDR_W]);
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic [ADDR_W-1:0] bases [6];
		reply_t            typed_rep;
		status_t           st;
		int                sent;
		int                p;
		int                k;
		bases[0] = 32'h0000_0000;
		bases[1] = 32'hFFFF_F000;
		bases[2] = 32'hFFFF_FFFF;
		bases[3] = $urandom & ~ALIGN_MASK;
		bases[4] = $urandom;
		bases[5] = 32'h0000_0FFF;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (k = 0; k < $size(opening_probes); k++) begin
			typed_rep.st = opening_probes[k].want_st;
			typed_rep.chunk = opening_probes[k].want_chunk;
			send_req(opening_probes[k].op, opening_probes[k].addr,
				opening_probes[k].typed, typed_rep, st);
		end

		// random phases, one pool base each
		for (p = 0; p < 6; p++) begin
			set_pool_base(bases[p]);
			sent = 0;
			if (p == 0 || $urandom_range(0, 2) == 0) begin
				send_op(FUNC_INIT, $urandom, st);
				sent++;
			end
			if (p == 1 || p == 4)
				choke_replies = 1'b1;
			if (p == 0)
				drain_pool(sent);
			while (sent < PHASE_ITEMS)
				random_req(sent);
		end

		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Run limit
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
